// ===== hdl/takf_pkg.sv =====
package takf_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0]
    {
        REG_ANGLE_NOISE = 3'd0,
        REG_BIAS_NOISE  = 3'd1,
        REG_MEAS_NOISE  = 3'd2,
        REG_TIME_STEP   = 3'd3
    } reg_index_t;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 27;

    typedef struct packed
    {
        logic signed [31:0] accel_angle;
        logic signed [31:0] gyro_rate;
    } in_item_t;

    typedef struct packed
    {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
        logic signed [31:0] corrected_rate;
    } out_item_t;

    // ALU operations
    typedef enum logic [1:0]
    {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef enum logic [1:0]
    {
        DIV_IDLE = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_DONE = 2'd2
    } div_state_t;

    typedef enum logic [1:0]
    {
        SEQ_IDLE  = 2'd0,
        SEQ_RUN   = 2'd1,
        SEQ_DIV   = 2'd2,
        SEQ_OUT   = 2'd3
    } seq_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/takf_alu.sv =====
module takf_alu #(
    parameter int FRAC_BITS = 20
) (
    input  logic               clk,
    input  takf_pkg::alu_req_t req,
    output logic signed [31:0] result
);
    import takf_pkg::*;

    logic signed [65:0] prod;
    logic signed [65:0] wide;
    logic signed [31:0] result_reg;
    logic signed [31:0] result_next;

    // product with half-LSB rounding, floor shift
    assign prod = 66'(req.a) * 66'(req.b) + (66'sd1 <<< (FRAC_BITS - 1));

    always_comb
    begin
        case (req.op)
            OP_ADD:  wide = 66'(req.a) + 66'(req.b);
            OP_SUB:  wide = 66'(req.a) - 66'(req.b);
            OP_MUL:  wide = prod >>> FRAC_BITS;
            default: wide = 66'(req.a);
        endcase
        result_next = sat32(wide);
    end

    // register the result
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
endmodule

// ===== hdl/takf_div.sv =====
module takf_div #(
    parameter int FRAC_BITS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    import takf_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    div_state_t          state_reg, state_next;
    logic [NW-1:0]       q_reg, q_next;
    logic [32:0]         rem_reg, rem_next;
    logic [31:0]         d_reg, d_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [33:0]         trial;
    logic signed [NW+1:0] signed_q;
    logic [31:0]         num_mag;
    logic [31:0]         den_mag;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);
    assign trial = {rem_reg, q_reg[NW-1]} - {2'b00, d_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == CW'(NW - 1)) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // restoring shift-subtract, one quotient bit per cycle
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                q_next    = {num_mag, {FRAC_BITS{1'b0}}};
                rem_next  = '0;
                d_next    = den_mag;
                neg_next  = num[31] ^ den[31];
                zero_next = (den == 32'sd0);
                cnt_next  = '0;
            end
            DIV_RUN:
            begin
                if (!trial[33])
                begin
                    rem_next = trial[32:0];
                    q_next   = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], q_reg[NW-1]};
                    q_next   = {q_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
    end

    // apply sign and saturate
    assign signed_q = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign done = (state_reg == DIV_DONE);
    assign quot = zero_reg ? 32'sd0 : sat32(66'(signed_q));
endmodule

// ===== hdl/tilt_angle_kalman_filter_top.sv =====
// Two-state tilt Kalman filter (angle and gyro bias) for one axis, signed
// Q(32-FRAC_BITS).FRAC_BITS. An item runs through one shared saturating
// add/sub/multiply unit under a micro-sequencer (28 operations) plus two
// serial divisions, one quotient bit per cycle. in_stall is high while an
// item is in flight and while the result waits in the output register.
// Write the configuration registers only while no item is in flight.
module tilt_angle_kalman_filter_top #(
    parameter int FRAC_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [26:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  takf_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output takf_pkg::out_item_t  out_data
);
    import takf_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam int NREG = 16;

    // register file slots
    localparam logic [3:0] R_ANG = 4'd0, R_BIAS = 4'd1, R_P0 = 4'd2, R_P1 = 4'd3,
        R_P2 = 4'd4, R_P3 = 4'd5, R_QA = 4'd6, R_QB = 4'd7, R_RM = 4'd8,
        R_DT = 4'd9, R_ACC = 4'd10, R_GY = 4'd11, R_T0 = 4'd12, R_T1 = 4'd13,
        R_K0 = 4'd14, R_K1 = 4'd15;

    typedef struct packed
    {
        alu_op_t    op;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] d;
        logic       a_zero;
    } uop_t;

    logic signed [31:0] rf_reg [NREG];
    logic signed [31:0] t2_reg, e_reg, k0_reg, k1_reg;
    seq_state_t         state_reg, state_next;
    logic [4:0]         pc_reg, pc_next;
    logic               phase_reg, phase_next;
    logic               dsel_reg, dsel_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg;
    alu_req_t           req;
    logic signed [31:0] alu_y;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_q;
    uop_t               uop;

    // reset contents of the register file slots
    function automatic logic signed [31:0] rf_init(input logic [3:0] slot);
        logic signed [31:0] v;
        case (slot)
            R_P0, R_P3: v = ONE;
            R_QA:       v = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
            R_QB:       v = 32'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
            R_RM:       v = ONE >>> 1;
            R_DT:       v = 32'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
            default:    v = 32'sd0;
        endcase
        return v;
    endfunction

    // micro-program; T0 slot carries scratch values, E/K in own registers
    // slot 12=T0 (scratch x), 13=T1 (scratch y), 14/15 gains
    function automatic uop_t prog(input logic [4:0] pc);
        uop_t u;
        u = '{OP_ADD, 4'd0, 4'd0, 4'd0, 1'b0};
        case (pc)
            5'd0:  u = '{OP_SUB, R_GY, R_BIAS, R_T0, 1'b0};
            5'd1:  u = '{OP_MUL, R_T0, R_DT, R_T0, 1'b0};
            5'd2:  u = '{OP_ADD, R_ANG, R_T0, R_ANG, 1'b0};
            5'd3:  u = '{OP_SUB, R_QA, R_P1, R_T0, 1'b0};
            5'd4:  u = '{OP_SUB, R_T0, R_P2, R_T0, 1'b0};
            5'd5:  u = '{OP_MUL, R_T0, R_DT, R_T0, 1'b0};
            5'd6:  u = '{OP_ADD, R_P0, R_T0, R_P0, 1'b0};
            5'd7:  u = '{OP_SUB, R_P3, R_P3, R_T1, 1'b1};
            5'd8:  u = '{OP_MUL, R_T1, R_DT, R_T1, 1'b0};
            5'd9:  u = '{OP_ADD, R_P1, R_T1, R_P1, 1'b0};
            5'd10: u = '{OP_ADD, R_P2, R_T1, R_P2, 1'b0};
            5'd11: u = '{OP_MUL, R_QB, R_DT, R_T0, 1'b0};
            5'd12: u = '{OP_ADD, R_P3, R_T0, R_P3, 1'b0};
            5'd13: u = '{OP_ADD, R_RM, R_P0, R_K0, 1'b0};
            // divisions run here; K0/K1 loaded from divider
            5'd14: u = '{OP_MUL, R_K0, R_P0, R_T0, 1'b0};
            5'd15: u = '{OP_MUL, R_K0, R_P1, R_T1, 1'b0};
            5'd16: u = '{OP_MUL, R_K1, R_P0, R_QB, 1'b0};
            5'd17: u = '{OP_MUL, R_K1, R_P1, R_RM, 1'b0};
            default: u = '{OP_ADD, 4'd0, 4'd0, 4'd0, 1'b0};
        endcase
        return u;
    endfunction

    // second program phase after covariance products
    logic [4:0] pc2;
    assign uop = prog(pc_reg);
    assign pc2 = pc_reg;

    // sequential ops not expressible as table: handled in step logic below
    always_comb
    begin
        req.op = uop.op;
        req.a  = uop.a_zero ? 32'sd0 : rf_reg[uop.a];
        req.b  = rf_reg[uop.b];
        case (pc2)
            5'd18: begin req.op = OP_SUB; req.a = rf_reg[R_P0]; req.b = rf_reg[R_T0]; end
            5'd19: begin req.op = OP_SUB; req.a = rf_reg[R_P1]; req.b = rf_reg[R_T1]; end
            5'd20: begin req.op = OP_SUB; req.a = rf_reg[R_P2]; req.b = t2_reg; end
            5'd21: begin req.op = OP_SUB; req.a = rf_reg[R_P3]; req.b = e_reg; end
            5'd22: begin req.op = OP_SUB; req.a = rf_reg[R_ACC]; req.b = rf_reg[R_ANG]; end
            5'd23: begin req.op = OP_MUL; req.a = k0_reg; req.b = rf_reg[R_T0]; end
            5'd24: begin req.op = OP_ADD; req.a = rf_reg[R_ANG]; req.b = rf_reg[R_T1]; end
            5'd25: begin req.op = OP_MUL; req.a = k1_reg; req.b = rf_reg[R_T0]; end
            5'd26: begin req.op = OP_ADD; req.a = rf_reg[R_BIAS]; req.b = rf_reg[R_T1]; end
            5'd27: begin req.op = OP_SUB; req.a = rf_reg[R_GY]; req.b = rf_reg[R_BIAS]; end
            default: ;
        endcase
    end

    takf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.clk(clk), .req(req), .result(alu_y));

    assign div_num   = dsel_reg ? rf_reg[R_P2] : rf_reg[R_P0];
    assign div_start = (state_reg == SEQ_DIV) && !phase_reg;

    takf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(e_reg),
        .done(div_done), .quot(div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        dsel_next  = dsel_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                    phase_next = 1'b0;
                end
            end
            SEQ_RUN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    pc_next = pc_reg + 1'b1;
                    if (pc_reg == 5'd13)
                    begin
                        state_next = SEQ_DIV;
                        dsel_next  = 1'b0;
                        phase_next = 1'b0;
                    end
                    else if (pc_reg == 5'd27)
                        state_next = SEQ_OUT;
                end
            end
            SEQ_DIV:
            begin
                phase_next = 1'b1;
                if (div_done)
                begin
                    phase_next = 1'b0;
                    dsel_next  = 1'b1;
                    if (dsel_reg)
                        state_next = SEQ_RUN;
                end
            end
            SEQ_OUT:   state_next = SEQ_IDLE;
            default:   state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            pc_reg        <= '0;
            phase_reg     <= 1'b0;
            dsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            dsel_reg      <= dsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == SEQ_OUT)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // register file writes: config, load, alu writeback, divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                rf_reg[i] <= rf_init(4'(i));
            t2_reg <= '0;
            e_reg  <= '0;
            k0_reg <= '0;
            k1_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    2'(REG_ANGLE_NOISE): rf_reg[R_QA] <= 32'(cfg_data[20:0]);
                    2'(REG_BIAS_NOISE):  rf_reg[R_QB] <= 32'(cfg_data[20:0]);
                    2'(REG_MEAS_NOISE):  rf_reg[R_RM] <= 32'(cfg_data);
                    2'(REG_TIME_STEP):   rf_reg[R_DT] <= 32'(cfg_data[20:0]);
                    default: ;
                endcase
            end
            if (state_reg == SEQ_IDLE && in_valid && !out_valid_reg)
            begin
                rf_reg[R_ACC] <= in_data.accel_angle;
                rf_reg[R_GY]  <= in_data.gyro_rate;
            end
            if (state_reg == SEQ_DIV && div_done)
            begin
                if (dsel_reg) k1_reg <= div_q;
                else          k0_reg <= div_q;
                if (dsel_reg) rf_reg[R_K1] <= div_q;
                else          rf_reg[R_K0] <= div_q;
            end
            if (state_reg == SEQ_RUN && phase_reg)
            begin
                case (pc_reg)
                    5'd13: e_reg <= alu_y;
                    5'd16: t2_reg <= alu_y;
                    5'd17: e_reg <= alu_y;
                    5'd18: rf_reg[R_P0] <= alu_y;
                    5'd19: rf_reg[R_P1] <= alu_y;
                    5'd20: rf_reg[R_P2] <= alu_y;
                    5'd21: rf_reg[R_P3] <= alu_y;
                    5'd22: rf_reg[R_T0] <= alu_y;
                    5'd23: rf_reg[R_T1] <= alu_y;
                    5'd24: rf_reg[R_ANG] <= alu_y;
                    5'd25: rf_reg[R_T1] <= alu_y;
                    5'd26: rf_reg[R_BIAS] <= alu_y;
                    5'd27: ;
                    default: rf_reg[uop.d] <= alu_y;
                endcase
            end
        end
    end

    // capture result
    always_ff @(posedge clk)
    begin
        if (state_reg == SEQ_RUN && phase_reg && pc_reg == 5'd27)
        begin
            out_reg.angle_estimate <= rf_reg[R_ANG];
            out_reg.bias_estimate  <= rf_reg[R_BIAS];
            out_reg.corrected_rate <= alu_y;
        end
    end

    assign in_stall  = (state_reg != SEQ_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import takf_pkg::*;

    localparam int FRAC = 20;
    localparam int N_RANDOM = 1530;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [26:0] cfg_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    tilt_angle_kalman_filter_top #(.FRAC_BITS(FRAC)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    // filter copy: registers and state
    logic signed [31:0] q_angle_noise, q_bias_noise, r_meas, dt_cur;
    logic signed [31:0] est_angle, est_bias;
    logic signed [31:0] p00, p01, p10, p11;

    out_item_t pending_results[$];
    int mismatches;
    int cycles;
    bit timed_out;
    bit idle_off;

    // clock
    always #6 clk = ~clk;

    function automatic logic signed [31:0] clip(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a, b);
        return clip(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a, b);
        return clip(66'(a) - 66'(b));
    endfunction

    // round half up, arithmetic shift is a floor
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b) + (66'sd1 <<< (FRAC - 1));
        return clip(p >>> FRAC);
    endfunction

    // truncate toward zero; zero denominator gives zero gain
    function automatic logic signed [31:0] qdiv(input logic signed [31:0] n, d);
        logic signed [65:0] num;
        if (d == 0)
            return 32'sd0;
        num = 66'(n) <<< FRAC;
        return clip(num / 66'(d));
    endfunction

    task automatic reset_filter();
        q_angle_noise = 1049;
        q_bias_noise = 3146;
        r_meas = 524288;
        dt_cur = 20972;
        est_angle = 0;
        est_bias = 0;
        p00 = 32'sd1048576;
        p01 = 0;
        p10 = 0;
        p11 = 32'sd1048576;
    endtask

    // advance the filter by one sample and return the expected result
    function automatic out_item_t kalman_step(input in_item_t s);
        logic signed [31:0] d0, dneg, e, k0, k1, t0, t1, innov;
        out_item_t r;
        est_angle = sadd(est_angle, qmul(ssub(s.gyro_rate, est_bias), dt_cur));
        d0 = ssub(ssub(q_angle_noise, p01), p10);
        dneg = clip(-66'(p11));
        p00 = sadd(p00, qmul(d0, dt_cur));
        p01 = sadd(p01, qmul(dneg, dt_cur));
        p10 = sadd(p10, qmul(dneg, dt_cur));
        p11 = sadd(p11, qmul(q_bias_noise, dt_cur));
        t0 = p00;
        t1 = p01;
        e = sadd(r_meas, t0);
        k0 = qdiv(t0, e);
        k1 = qdiv(p10, e);
        p00 = ssub(p00, qmul(k0, t0));
        p01 = ssub(p01, qmul(k0, t1));
        p10 = ssub(p10, qmul(k1, t0));
        p11 = ssub(p11, qmul(k1, t1));
        innov = ssub(s.accel_angle, est_angle);
        est_angle = sadd(est_angle, qmul(k0, innov));
        est_bias = sadd(est_bias, qmul(k1, innov));
        r.angle_estimate = est_angle;
        r.bias_estimate = est_bias;
        r.corrected_rate = ssub(s.gyro_rate, est_bias);
        return r;
    endfunction

    // write one register of the block and of the filter copy
    task automatic write_reg(input reg_index_t idx, input logic [26:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE: q_angle_noise = {11'd0, val[20:0]};
            REG_BIAS_NOISE:  q_bias_noise = {11'd0, val[20:0]};
            REG_MEAS_NOISE:  r_meas = {5'd0, val};
            REG_TIME_STEP:   dt_cur = {11'd0, val[20:0]};
            default: ;
        endcase
    endtask

    // send one sample; hold valid and payload while stalled
    task automatic send_sample(input in_item_t s, input logic has_expect,
                               input out_item_t want);
        do
            @(negedge clk);
        while (!idle_off && $urandom_range(99) < 27);
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        begin
            out_item_t r;
            r = kalman_step(s);
            if (has_expect && r !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row: model gave %h, table says %h", r, want);
            end
            pending_results.push_back(has_expect ? want : r);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !idle_off && ($urandom_range(99) < 27);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                out_item_t want;
                want = pending_results.pop_front();
                if (out_data.angle_estimate !== want.angle_estimate
                    || out_data.bias_estimate !== want.bias_estimate
                    || out_data.corrected_rate !== want.corrected_rate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h, got %h %h %h",
                                 want.angle_estimate, want.bias_estimate,
                                 want.corrected_rate, out_data.angle_estimate,
                                 out_data.bias_estimate, out_data.corrected_rate);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL tilt_angle_kalman_filter_top");
            $finish;
        end
    end

    typedef struct
    {
        int signed a;
        int signed g;
        bit chk;
        out_item_t res;
    } stim_row_t;

    stim_row_t rows[$];

    initial
    begin
        in_item_t s;
        out_item_t none;
        int n;
        int phase;
        clk = 1'b0;
        mismatches = 0;
        cycles = 0;
        timed_out = 0;
        idle_off = 0;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        reset_filter();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: first sample after reset with zero inputs stays at zero
        rows.push_back('{0, 0, 1'b1, '0});
        rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 1'b0, none});
        rows.push_back('{32'sh80000000, 32'sh80000000, 1'b0, none});
        rows.push_back('{32'sh80000000, 32'sh7fffffff, 1'b0, none});
        rows.push_back('{32'sh7fffffff, 32'sh80000000, 1'b0, none});
        rows.push_back('{32'sh00100000, 32'sh00100000, 1'b0, none});
        rows.push_back('{-32'sh00100000, 32'sh00000001, 1'b0, none});
        rows.push_back('{32'sh55555555, 32'shaaaaaaaa, 1'b0, none});
        rows.push_back('{32'shaaaaaaaa, 32'sh55555555, 1'b0, none});
        rows.push_back('{-1, -1, 1'b0, none});
        foreach (rows[i])
        begin
            s.accel_angle = rows[i].a;
            s.gyro_rate = rows[i].g;
            send_sample(s, rows[i].chk, rows[i].res);
        end
        drain();

        // zero measurement noise and extreme registers masked from all-ones
        write_reg(REG_MEAS_NOISE, 27'd0);
        write_reg(REG_ANGLE_NOISE, 27'h7ffffff);
        write_reg(REG_BIAS_NOISE, 27'd0);
        write_reg(REG_TIME_STEP, 27'h7ffffff);
        for (int i = 0; i < 6; i++)
        begin
            s.accel_angle = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
            s.gyro_rate = (i % 3 == 0) ? 32'sh80000000 : $urandom;
            send_sample(s, 1'b0, none);
        end
        drain();

        // random phases, each with its own register setting
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(REG_ANGLE_NOISE, 27'd1049);
                    write_reg(REG_BIAS_NOISE, 27'd3146);
                    write_reg(REG_MEAS_NOISE, 27'd524288);
                    write_reg(REG_TIME_STEP, 27'd20972);
                end
                1: begin
                    write_reg(REG_ANGLE_NOISE, 27'd0);
                    write_reg(REG_BIAS_NOISE, 27'd1048576);
                    write_reg(REG_MEAS_NOISE, 27'd1);
                    write_reg(REG_TIME_STEP, 27'd1);
                end
                2: begin
                    write_reg(REG_ANGLE_NOISE, 27'd1048576);
                    write_reg(REG_BIAS_NOISE, 27'd0);
                    write_reg(REG_MEAS_NOISE, 27'd104857600);
                    write_reg(REG_TIME_STEP, 27'd1048576);
                end
                default: begin
                    write_reg(REG_ANGLE_NOISE, 27'($urandom));
                    write_reg(REG_BIAS_NOISE, 27'($urandom));
                    write_reg(REG_MEAS_NOISE, 27'($urandom_range(104857600, 1)));
                    write_reg(REG_TIME_STEP, 27'($urandom));
                end
            endcase
            idle_off = (phase == 4);
            for (n = 0; n < N_RANDOM / 6; n++)
            begin
                // mostly plausible angles and rates, some full-range noise
                if ($urandom_range(9) < 7)
                begin
                    s.accel_angle = $signed($urandom_range(188743680)) - 94371840;
                    s.gyro_rate = $signed($urandom_range(524288000)) - 262144000;
                end
                else
                begin
                    s.accel_angle = $urandom;
                    s.gyro_rate = $urandom;
                end
                send_sample(s, 1'b0, none);
            end
            idle_off = 0;
            drain();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS tilt_angle_kalman_filter_top");
        else
            $display("FAIL tilt_angle_kalman_filter_top");
        $finish;
    end

endmodule

// ===== tilt_angle_kalman_filter_top.f =====
hdl/takf_pkg.sv
hdl/takf_alu.sv
hdl/takf_div.sv
hdl/tilt_angle_kalman_filter_top.sv
bench/tb_top.sv
